FILE: rtl/core/ilie_pkg.sv
// Shared types and codes for the indexed list store.
// No dependencies; imported by every module of the block.
package ilie_pkg;

  typedef enum logic [2:0] {
    CMD_APPEND = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_READ   = 3'd4,
    CMD_CLEAR  = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BAD   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // memory work still to do for the word in flight
  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUT,
    OP_INS,
    OP_ERA,
    OP_RD
  } op_t;

  typedef struct packed {
    logic start;
    logic rd_en;
    logic wr_shift;
    logic wr_val;
    logic commit;
  } ctl_t;

  typedef struct packed {
    op_t  op;
    logic left_zero;
  } sts_t;

endpackage

FILE: rtl/core/ilie_ctrl.sv
// Sequencer for the indexed list store: handshakes and memory sweep control.
// Depends on ilie_pkg; drives ilie_datapath through ctl_t / sts_t.
module ilie_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  ilie_pkg::sts_t sts,
  output ilie_pkg::ctl_t ctl
);
  import ilie_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_DISPATCH = 5'b00010,
    S_SHIFT    = 5'b00100,
    S_PUT      = 5'b01000,
    S_DONE     = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.start = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts.op) inside
          OP_INS, OP_ERA: begin
            if (!sts.left_zero) begin
              ctl.rd_en = 1'b1;
              state_nxt = S_SHIFT;
            end else begin
              state_nxt = (sts.op == OP_INS) ? S_PUT : S_DONE;
            end
          end
          OP_RD: begin
            ctl.rd_en = 1'b1;
            state_nxt = S_DONE;
          end
          OP_PUT: state_nxt = S_PUT;
          default: state_nxt = S_DONE;
        endcase
      end
      S_SHIFT: begin
        ctl.wr_shift = 1'b1;
        if (!sts.left_zero) begin
          ctl.rd_en = 1'b1;
        end else begin
          state_nxt = (sts.op == OP_INS) ? S_PUT : S_DONE;
        end
      end
      S_PUT: begin
        ctl.wr_val = 1'b1;
        state_nxt  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          ctl.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (ctl.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign out_valid = out_valid_r && rst_n;

endmodule

FILE: rtl/core/ilie_datapath.sv
// Entry memory, count, command decode, sweep address counters and result word.
// Depends on ilie_pkg; controlled by ilie_ctrl.
module ilie_datapath #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  ilie_pkg::ctl_t ctl,
  output ilie_pkg::sts_t sts,
  input  logic [2:0]     in_command,
  input  logic [31:0]    in_value,
  input  logic [6:0]     in_position,
  input  logic [6:0]     in_range_end,
  output logic [1:0]     out_status,
  output logic [31:0]    out_read_value,
  output logic [6:0]     out_count,
  output logic           out_empty_res
);
  import ilie_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int XW = (CW > 7) ? CW : 7;

  logic [ELEMENT_WIDTH-1:0] mem [CAPACITY];
  logic [ELEMENT_WIDTH-1:0] rdata_r;
  logic [ELEMENT_WIDTH-1:0] val_r;
  logic [ELEMENT_WIDTH-1:0] wdata;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic [AW-1:0] rd_addr_r, rd_addr_nxt;
  logic [AW-1:0] wr_addr_r, wr_addr_nxt;
  logic          dn_r, dn_nxt;
  op_t           op_r, op_nxt;
  status_t       status_r, status_nxt;

  logic [XW-1:0] cnt_x, pos_x, end_x, cap_x;

  status_t       out_status_r;
  logic [31:0]   out_read_value_r;
  logic [6:0]    out_count_r;
  logic          out_empty_r;

  assign cnt_x = XW'(count_r);
  assign pos_x = XW'(in_position);
  assign end_x = XW'(in_range_end);
  assign cap_x = XW'(CAPACITY);

  always_comb begin
    op_nxt      = OP_NONE;
    status_nxt  = ST_OK;
    count_nxt   = count_r;
    left_nxt    = '0;
    rd_addr_nxt = '0;
    wr_addr_nxt = '0;
    dn_nxt      = 1'b0;
    unique case (cmd_t'(in_command))
      CMD_APPEND: begin
        if (cnt_x >= cap_x) begin
          status_nxt = ST_FULL;
        end else begin
          op_nxt      = OP_PUT;
          wr_addr_nxt = AW'(count_r);
          count_nxt   = count_r + CW'(1);
        end
      end
      CMD_REMOVE: begin
        if (count_r == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      CMD_INSERT: begin
        if (pos_x > cnt_x) begin
          status_nxt = ST_BAD;
        end else if (cnt_x >= cap_x) begin
          status_nxt = ST_FULL;
        end else begin
          op_nxt      = OP_INS;
          dn_nxt      = 1'b1;
          rd_addr_nxt = AW'(count_r - CW'(1));
          wr_addr_nxt = AW'(count_r);
          left_nxt    = CW'(cnt_x - pos_x);
          count_nxt   = count_r + CW'(1);
        end
      end
      CMD_ERASE: begin
        if (pos_x >= end_x || end_x > cnt_x) begin
          status_nxt = ST_BAD;
        end else begin
          op_nxt      = OP_ERA;
          rd_addr_nxt = AW'(end_x);
          wr_addr_nxt = AW'(pos_x);
          left_nxt    = CW'(cnt_x - end_x);
          count_nxt   = CW'(cnt_x - (end_x - pos_x));
        end
      end
      CMD_READ: begin
        if (pos_x >= cnt_x) begin
          status_nxt = ST_BAD;
        end else begin
          op_nxt      = OP_RD;
          rd_addr_nxt = AW'(pos_x);
        end
      end
      CMD_CLEAR: count_nxt = '0;
      default:   status_nxt = ST_BAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      op_r    <= OP_NONE;
    end else if (ctl.start) begin
      count_r <= count_nxt;
      op_r    <= op_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      status_r  <= status_nxt;
      val_r     <= ELEMENT_WIDTH'(in_value);
      rd_addr_r <= rd_addr_nxt;
      wr_addr_r <= wr_addr_nxt;
      left_r    <= left_nxt;
      dn_r      <= dn_nxt;
    end else begin
      if (ctl.rd_en) begin
        rd_addr_r <= dn_r ? rd_addr_r - AW'(1) : rd_addr_r + AW'(1);
        left_r    <= left_r - CW'(1);
      end
      if (ctl.wr_shift) begin
        wr_addr_r <= dn_r ? wr_addr_r - AW'(1) : wr_addr_r + AW'(1);
      end
    end
  end

  assign wdata = ctl.wr_shift ? rdata_r : val_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_shift || ctl.wr_val) begin
      mem[wr_addr_r] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata_r <= mem[rd_addr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      out_status_r     <= status_r;
      out_read_value_r <= (op_r == OP_RD) ? 32'(rdata_r) : '0;
      out_count_r      <= 7'(count_r);
      out_empty_r      <= (count_r == '0);
    end
  end

  assign sts.op        = op_r;
  assign sts.left_zero = (left_r == '0);

  assign out_status     = out_status_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;
  assign out_empty_res  = out_empty_r;

endmodule

FILE: rtl/core/indexed_list_insert_erase.sv
// Top level of the indexed list store: sequencer plus datapath.
// Depends on ilie_pkg, ilie_ctrl, ilie_datapath.
//
//   channel  handshake            payload
//   in_      in_valid / in_stall   command, value, position, range_end
//   out_     out_valid / out_stall status, read_value, count, empty_res
//
// One word at a time. Insert and erase sweep the entries that lie past the
// position or range end; the other commands finish without a sweep.
// The shift moves one entry per cycle through the single-port-pair memory.
// Reset clears the count and handshake state; the entry memory is not cleared.
// A finished result waits in the output register, and the next word is
// accepted meanwhile; the sequencer holds in its final state while it waits.
module indexed_list_insert_erase #(
  parameter int CAPACITY      = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_value,
  input  logic [6:0]  in_position,
  input  logic [6:0]  in_range_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_value,
  output logic [6:0]  out_count,
  output logic        out_empty_res
);
  import ilie_pkg::*;

  ctl_t ctl;
  sts_t sts;

  ilie_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  ilie_datapath #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .sts            (sts),
    .in_command     (in_command),
    .in_value       (in_value),
    .in_position    (in_position),
    .in_range_end   (in_range_end),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_count      (out_count),
    .out_empty_res  (out_empty_res)
  );

endmodule

FILE: rtl/core/ilie_checker.sv
// Port-level checks for the indexed list store, bound to the top level.
// Depends on ilie_pkg and indexed_list_insert_erase.
module ilie_checker #(
  parameter int CAPACITY = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic [31:0] out_read_value,
  input logic [6:0]  out_count,
  input logic        out_empty_res
);
  import ilie_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) && $stable(out_count)
      && $stable(out_read_value) && $stable(out_empty_res))
    else $error("stalled result word changed");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word accepted while busy");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_empty_res == (out_count == 7'd0)))
    else $error("empty flag disagrees with count");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_count) <= CAPACITY || CAPACITY > 127))
    else $error("count above capacity");

  a_rdata: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_read_value == 32'd0)
    else $error("read data on failed command");

endmodule

bind indexed_list_insert_erase ilie_checker #(.CAPACITY(CAPACITY)) u_ilie_checker (.*);

FILE: verif/ilie_reply_checker.sv
// Reply checker for the indexed list store: keeps a shadow copy of the list,
// predicts the reply word for every accepted command word and compares them.
// Depends on ilie_pkg; instantiated by tb_indexed_list_insert_erase.
module ilie_reply_checker #(
  parameter int CAPACITY = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_value,
  input  logic [6:0]  in_position,
  input  logic [6:0]  in_range_end,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_read_value,
  input  logic [6:0]  out_count,
  input  logic        out_empty_res,
  output int          fail_count,
  output int          pending,
  output logic [6:0]  list_len
);
  timeunit 1ns;
  timeprecision 1ps;
  import ilie_pkg::*;

  typedef struct packed {
    status_t     status;
    logic [31:0] read_value;
    logic [6:0]  count;
    logic        empty_res;
  } reply_t;

  logic [31:0] shadow_entries [CAPACITY];
  int          shadow_len;
  reply_t      predicted_replies [$];
  reply_t      next_reply;
  reply_t      oldest;

  task automatic apply_list_command(input logic [2:0] cmd, input logic [31:0] val,
                                    input logic [6:0] pos, input logic [6:0] rend,
                                    output reply_t reply);
    int gap;
    int i;
    reply.status     = ST_OK;
    reply.read_value = '0;
    case (cmd)
      CMD_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          reply.status = ST_FULL;
        end else begin
          shadow_entries[shadow_len] = val;
          shadow_len++;
        end
      end
      CMD_REMOVE: begin
        if (shadow_len == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          shadow_len--;
        end
      end
      CMD_INSERT: begin
        if (int'(pos) > shadow_len) begin
          reply.status = ST_BAD;
        end else if (shadow_len >= CAPACITY) begin
          reply.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > int'(pos); i--)
            shadow_entries[i] = shadow_entries[i - 1];
          shadow_entries[pos] = val;
          shadow_len++;
        end
      end
      CMD_ERASE: begin
        if (pos >= rend || int'(rend) > shadow_len) begin
          reply.status = ST_BAD;
        end else begin
          gap = int'(rend) - int'(pos);
          for (i = int'(pos); i < shadow_len - gap; i++)
            shadow_entries[i] = shadow_entries[i + gap];
          shadow_len = shadow_len - gap;
        end
      end
      CMD_READ: begin
        if (int'(pos) >= shadow_len) begin
          reply.status = ST_BAD;
        end else begin
          reply.read_value = shadow_entries[pos];
        end
      end
      CMD_CLEAR: begin
        shadow_len = 0;
      end
      default: begin
        reply.status = ST_BAD;
      end
    endcase
    reply.count     = shadow_len[6:0];
    reply.empty_res = (shadow_len == 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_len = 0;
      predicted_replies.delete();
      fail_count = 0;
      pending    = 0;
      list_len   = '0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_list_command(in_command, in_value, in_position, in_range_end, next_reply);
        predicted_replies = {predicted_replies, next_reply};
      end
      if (out_valid && !out_stall) begin
        if (predicted_replies.size() == 0) begin
          fail_count++;
          $display("%0t: unpredicted reply word: status %0d data %h count %0d empty %0b",
                   $time, out_status, out_read_value, out_count, out_empty_res);
        end else begin
          oldest = predicted_replies.pop_front();
          if (oldest.status !== out_status || oldest.read_value !== out_read_value ||
              oldest.count !== out_count || oldest.empty_res !== out_empty_res) begin
            fail_count++;
            $display({"%0t: expected status %0d data %h count %0d empty %0b, ",
                      "got status %0d data %h count %0d empty %0b"},
                     $time, oldest.status, oldest.read_value, oldest.count,
                     oldest.empty_res, out_status, out_read_value, out_count,
                     out_empty_res);
          end
        end
      end
      pending  = predicted_replies.size();
      list_len = shadow_len[6:0];
    end
  end

endmodule

FILE: verif/tb_indexed_list_insert_erase.sv
// Testbench top for the indexed list store: directed and random command
// words with bursty input and a stalling receiver; checking in ilie_reply_checker.
// Depends on ilie_pkg, indexed_list_insert_erase and ilie_reply_checker.
module tb_indexed_list_insert_erase;
  timeunit 1ns;
  timeprecision 1ps;
  import ilie_pkg::*;

  localparam int         RANDOM_WORDS     = 1250;
  localparam int         LONG_HOLD_CYCLES = 400;
  localparam logic [2:0] CMD_UNUSED_6     = 3'd6;
  localparam logic [2:0] CMD_UNUSED_7     = 3'd7;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} mix_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_command = '0;
  logic [31:0] in_value = '0;
  logic [6:0]  in_position = '0;
  logic [6:0]  in_range_end = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_status;
  logic [31:0] out_read_value;
  logic [6:0]  out_count;
  logic        out_empty_res;
  int          fail_count;
  int          pending;
  logic [6:0]  list_len;

  always #6 clk = ~clk;

  indexed_list_insert_erase u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_value       (in_value),
    .in_position    (in_position),
    .in_range_end   (in_range_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_count      (out_count),
    .out_empty_res  (out_empty_res)
  );

  ilie_reply_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_value       (in_value),
    .in_position    (in_position),
    .in_range_end   (in_range_end),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_count      (out_count),
    .out_empty_res  (out_empty_res),
    .fail_count     (fail_count),
    .pending        (pending),
    .list_len       (list_len)
  );

  // called at a falling edge; returns at the falling edge after the word is taken
  task automatic send_word(input logic [2:0] cmd, input logic [31:0] val,
                           input logic [6:0] pos, input logic [6:0] rend);
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_value     <= val;
    in_position  <= pos;
    in_range_end <= rend;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic hold_input(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic send_random(input mix_t mix);
    logic [2:0]  cmd;
    logic [31:0] val;
    logic [6:0]  pos;
    logic [6:0]  rend;
    int          len;
    int          r;
    len = int'(list_len);
    r   = $urandom_range(0, 99);
    case (mix)
      MIX_GROW: begin
        if (r < 40) cmd = CMD_APPEND;
        else if (r < 75) cmd = CMD_INSERT;
        else if (r < 88) cmd = CMD_READ;
        else if (r < 92) cmd = CMD_REMOVE;
        else if (r < 96) cmd = CMD_ERASE;
        else if (r < 98) cmd = CMD_UNUSED_6;
        else cmd = CMD_UNUSED_7;
      end
      MIX_SHRINK: begin
        if (r < 30) cmd = CMD_REMOVE;
        else if (r < 60) cmd = CMD_ERASE;
        else if (r < 80) cmd = CMD_READ;
        else if (r < 88) cmd = CMD_INSERT;
        else if (r < 95) cmd = CMD_APPEND;
        else if (r < 97) cmd = CMD_CLEAR;
        else if (r < 98) cmd = CMD_UNUSED_6;
        else cmd = CMD_UNUSED_7;
      end
      default: begin
        if (r < 20) cmd = CMD_APPEND;
        else if (r < 35) cmd = CMD_REMOVE;
        else if (r < 55) cmd = CMD_INSERT;
        else if (r < 70) cmd = CMD_ERASE;
        else if (r < 92) cmd = CMD_READ;
        else if (r < 96) cmd = CMD_CLEAR;
        else if (r < 98) cmd = CMD_UNUSED_6;
        else cmd = CMD_UNUSED_7;
      end
    endcase
    val = $urandom;
    case ($urandom_range(0, 7))
      0: val = '0;
      1: val = '1;
      default: ;
    endcase
    rend = 7'($urandom_range(0, 127));
    if ($urandom_range(0, 7) == 0) begin
      pos = 7'($urandom_range(0, 127));
    end else if (cmd == CMD_INSERT) begin
      pos = 7'($urandom_range(0, len));
    end else if (len == 0) begin
      pos = '0;
    end else begin
      pos  = 7'($urandom_range(0, len - 1));
      rend = 7'($urandom_range(int'(pos) + 1, len));
    end
    send_word(cmd, val, pos, rend);
  endtask

  initial begin
    int seg;
    int mode;
    @(posedge rst_n);
    seg = 0;
    forever begin
      if (seg % 40 == 3) begin
        repeat (LONG_HOLD_CYCLES) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        mode = $urandom_range(0, 2);
        repeat ($urandom_range(20, 200)) begin
          @(negedge clk);
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= 1'($urandom_range(0, 1));
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
      seg++;
    end
  end

  initial begin
    int   sent;
    int   seg_left;
    mix_t mix;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_word(CMD_REMOVE, 32'h0, 7'd0, 7'd0);
    send_word(CMD_READ, 32'h0, 7'd0, 7'd0);
    send_word(CMD_ERASE, 32'h0, 7'd0, 7'd1);
    send_word(CMD_INSERT, 32'h1234_5678, 7'd1, 7'd0);
    send_word(CMD_INSERT, 32'hFFFF_FFFF, 7'd0, 7'd0);
    send_word(CMD_APPEND, 32'h0, 7'd0, 7'd0);
    send_word(CMD_APPEND, 32'hA5A5_5A5A, 7'd0, 7'd0);
    send_word(CMD_INSERT, 32'h5A5A_A5A5, 7'd127, 7'd0);
    send_word(CMD_INSERT, 32'h0000_0001, 7'd3, 7'd0);
    send_word(CMD_INSERT, 32'h8000_0000, 7'd1, 7'd0);
    send_word(CMD_READ, 32'h0, 7'd0, 7'd0);
    send_word(CMD_READ, 32'h0, 7'd4, 7'd0);
    send_word(CMD_READ, 32'h0, 7'd5, 7'd0);
    send_word(CMD_READ, 32'h0, 7'd127, 7'd127);
    send_word(CMD_ERASE, 32'h0, 7'd2, 7'd2);
    send_word(CMD_ERASE, 32'h0, 7'd3, 7'd2);
    send_word(CMD_ERASE, 32'h0, 7'd0, 7'd6);
    send_word(CMD_ERASE, 32'h0, 7'd0, 7'd127);
    send_word(CMD_ERASE, 32'h0, 7'd1, 7'd3);
    send_word(CMD_UNUSED_6, 32'hFFFF_FFFF, 7'd127, 7'd127);
    send_word(CMD_UNUSED_7, 32'h0, 7'd0, 7'd0);
    send_word(CMD_ERASE, 32'h0, 7'd0, 7'd3);
    send_word(CMD_APPEND, $urandom, 7'd0, 7'd0);
    send_word(CMD_CLEAR, 32'h0, 7'd0, 7'd0);
    send_word(CMD_CLEAR, 32'h0, 7'd0, 7'd0);

    sent     = 0;
    seg_left = 0;
    mix      = MIX_GROW;
    while (sent < RANDOM_WORDS) begin
      repeat ($urandom_range(1, 30)) begin
        if (seg_left == 0) begin
          mix      = mix_t'($urandom_range(0, 2));
          seg_left = $urandom_range(50, 200);
        end
        send_random(mix);
        seg_left--;
        sent++;
      end
      if ($urandom_range(0, 3) != 0) hold_input($urandom_range(1, 10));
    end
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (80) @(negedge clk);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/ilie_pkg.sv
rtl/core/ilie_ctrl.sv
rtl/core/ilie_datapath.sv
rtl/core/indexed_list_insert_erase.sv
rtl/core/ilie_checker.sv
verif/ilie_reply_checker.sv
verif/tb_indexed_list_insert_erase.sv
